// File: rtl/core/matrix3x3_inverse_unit_assert.svh
// ----------------------------------------------------------------------------
// matrix3x3_inverse_unit assertion macros
// Shared concurrent assertion forms for the matrix inverse unit.
// ----------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_UNIT_ASSERT_SVH
`define MATRIX3X3_INVERSE_UNIT_ASSERT_SVH

// same-cycle implication
`define M3INV_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define M3INV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/m3inv_pkg.sv
// ----------------------------------------------------------------------------
// m3inv_pkg
// Types and constants of the 3x3 matrix inverse unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package m3inv_pkg;

   // field and datapath widths
   localparam int unsigned ELEM_W    = 16;
   localparam int unsigned RES_W     = 32;
   localparam int unsigned PROD_W    = 32;
   localparam int unsigned COF_W     = 33;
   localparam int unsigned DP_W      = 49;
   localparam int unsigned DET_W     = 51;
   localparam int unsigned MAG_C_W   = 32;
   localparam int unsigned MAG_D_W   = 49;
   localparam int unsigned Q_SHIFT   = 24;
   localparam int unsigned NUM_W     = 56;
   localparam int unsigned QUO_W     = 33;
   localparam int unsigned CMP_W     = MAG_D_W + QUO_W;
   localparam int unsigned DIV_STEPS = QUO_W;
   localparam int unsigned N_ELEM    = 9;

   // front stages: input, products, cofactors, det products, det, magnitudes, numerators
   localparam int unsigned FRONT_STAGES = 7;

   // saturation limits of the result magnitude
   localparam logic [QUO_W-1:0] POS_LIMIT = 33'h0_7FFF_FFFF;
   localparam logic [QUO_W-1:0] NEG_LIMIT = 33'h0_8000_0000;
   localparam logic [RES_W-1:0] POS_SAT   = 32'h7FFF_FFFF;
   localparam logic [RES_W-1:0] NEG_SAT   = 32'h8000_0000;

   // adjugate (transposed cofactors) in row-major order: plus term a*b, minus term c*d
   localparam int unsigned COF_PA [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int unsigned COF_PB [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int unsigned COF_MA [N_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int unsigned COF_MB [N_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [RES_W-1:0]  res_type;

   // one stage of the restoring divider, nine lanes sharing one divisor
   typedef struct packed {
      logic [N_ELEM-1:0][NUM_W-1:0] rem;
      logic [N_ELEM-1:0][QUO_W-1:0] quo;
      logic [MAG_D_W-1:0]           md;
      logic [N_ELEM-1:0]            neg;
      logic [N_ELEM-1:0]            big;
      logic                         sing;
   } div_stage_type;

endpackage

// File: rtl/core/m3inv_req_if.sv
// ----------------------------------------------------------------------------
// m3inv_req_if
// Input channel: one 3x3 Q8.8 matrix per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface m3inv_req_if;
   logic               valid;
   logic               ready;
   m3inv_pkg::elem_type a00, a01, a02;
   m3inv_pkg::elem_type a10, a11, a12;
   m3inv_pkg::elem_type a20, a21, a22;

   modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                   input ready);
   modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                   output ready);
endinterface

// File: rtl/core/m3inv_rsp_if.sv
// ----------------------------------------------------------------------------
// m3inv_rsp_if
// Result channel: one Q16.16 inverse with flags per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface m3inv_rsp_if;
   logic               valid;
   logic               ready;
   m3inv_pkg::res_type r00, r01, r02;
   m3inv_pkg::res_type r10, r11, r12;
   m3inv_pkg::res_type r20, r21, r22;
   logic               singular;
   logic               overflow;

   modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   singular, overflow, input ready);
   modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   singular, overflow, output ready);
endinterface

// File: rtl/core/matrix3x3_inverse_unit.sv
// The unit inverts one signed Q8.8 3x3 matrix per beat by the adjugate method and returns
// nine Q16.16 elements, rounded to nearest with ties away from zero and saturated, plus
// singular and overflow flags. It takes a new matrix every cycle while it is not stalled.
// On the way to the output register, seven front stages form the products, cofactors,
// determinant and dividends, and 33 stages of a restoring divider, one quotient bit per
// stage in nine lanes, give the quotient. Stalls on the result side back up through the
// pipeline, which keeps advancing while a result waits until its last stage is full.
`timescale 1ns / 1ps

`include "matrix3x3_inverse_unit_assert.svh"

// ----------------------------------------------------------------------------
// matrix3x3_inverse_unit
// Pipelined 3x3 matrix inverse, Q8.8 in, Q16.16 out.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_unit (
   input  logic         clock,
   input  logic         reset,
   m3inv_req_if.sink    req,
   m3inv_rsp_if.source  rsp
);

   localparam int unsigned NE  = m3inv_pkg::N_ELEM;
   localparam int unsigned NST = m3inv_pkg::FRONT_STAGES + m3inv_pkg::DIV_STEPS + 1;
   localparam int unsigned DS  = m3inv_pkg::DIV_STEPS;

   // pipeline control
   logic [NST-1:0] vld_ff;
   logic           pipe_en;
   logic           out_vld_ff;

   // stage registers
   logic signed [m3inv_pkg::ELEM_W-1:0]  a_ff    [NE];
   logic signed [m3inv_pkg::ELEM_W-1:0]  a_in    [NE];
   logic signed [m3inv_pkg::PROD_W-1:0]  pp_ff   [NE];
   logic signed [m3inv_pkg::PROD_W-1:0]  pp_in   [NE];
   logic signed [m3inv_pkg::PROD_W-1:0]  pm_ff   [NE];
   logic signed [m3inv_pkg::PROD_W-1:0]  pm_in   [NE];
   logic signed [m3inv_pkg::ELEM_W-1:0]  r1a_ff  [3];
   logic signed [m3inv_pkg::ELEM_W-1:0]  r2a_ff  [3];
   logic signed [m3inv_pkg::COF_W-1:0]   cof_ff  [NE];
   logic signed [m3inv_pkg::COF_W-1:0]   cof_in  [NE];
   logic signed [m3inv_pkg::COF_W-1:0]   cof3_ff [NE];
   logic signed [m3inv_pkg::COF_W-1:0]   cof4_ff [NE];
   logic signed [m3inv_pkg::DP_W-1:0]    dp_ff   [3];
   logic signed [m3inv_pkg::DP_W-1:0]    dp_in   [3];
   logic signed [m3inv_pkg::DET_W-1:0]   det_ff;
   logic signed [m3inv_pkg::DET_W-1:0]   det_in;
   logic [m3inv_pkg::MAG_C_W-1:0]        mc_ff   [NE];
   logic [m3inv_pkg::MAG_C_W-1:0]        mc_in   [NE];
   logic [m3inv_pkg::MAG_D_W-1:0]        md5_ff, md5_in, md6_ff;
   logic [NE-1:0]                        neg5_ff, neg5_in, neg6_ff;
   logic                                 sing5_ff, sing5_in, sing6_ff;
   logic [m3inv_pkg::NUM_W-1:0]          num_ff  [NE];
   logic [m3inv_pkg::NUM_W-1:0]          num_in  [NE];
   m3inv_pkg::div_stage_type             dv_ff   [DS+1];
   m3inv_pkg::div_stage_type             dv_in   [DS+1];
   logic [m3inv_pkg::RES_W-1:0]          res_ff  [NE];
   logic [m3inv_pkg::RES_W-1:0]          res_in  [NE];
   logic                                 sing_ff, ovf_ff, ovf_in;

   // advance when the last stage is empty or the output register frees up
   assign pipe_en   = !vld_ff[NST-1] || !out_vld_ff || rsp.ready;
   assign req.ready = pipe_en;

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         if (pipe_en) begin
            vld_ff <= {vld_ff[NST-2:0], req.valid};
         end
         if (pipe_en && vld_ff[NST-1]) begin
            out_vld_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // input beat
   always_comb begin
      a_in[0] = req.a00;  a_in[1] = req.a01;  a_in[2] = req.a02;
      a_in[3] = req.a10;  a_in[4] = req.a11;  a_in[5] = req.a12;
      a_in[6] = req.a20;  a_in[7] = req.a21;  a_in[8] = req.a22;
   end

   // 2x2 minor products
   always_comb begin
      for (int i = 0; i < NE; i++) begin
         pp_in[i] = a_ff[m3inv_pkg::COF_PA[i]] * a_ff[m3inv_pkg::COF_PB[i]];
         pm_in[i] = a_ff[m3inv_pkg::COF_MA[i]] * a_ff[m3inv_pkg::COF_MB[i]];
      end
   end

   // adjugate entries (transposed cofactors) from the minor products
   always_comb begin
      for (int i = 0; i < NE; i++) begin
         cof_in[i] = $signed({pp_ff[i][m3inv_pkg::PROD_W-1], pp_ff[i]})
                   - $signed({pm_ff[i][m3inv_pkg::PROD_W-1], pm_ff[i]});
      end
   end

   // determinant terms along the first row
   always_comb begin
      dp_in[0] = r2a_ff[0] * cof_ff[0];
      dp_in[1] = r2a_ff[1] * cof_ff[3];
      dp_in[2] = r2a_ff[2] * cof_ff[6];
   end

   // determinant sum
   always_comb begin
      det_in = m3inv_pkg::DET_W'(dp_ff[0]) + m3inv_pkg::DET_W'(dp_ff[1])
             + m3inv_pkg::DET_W'(dp_ff[2]);
   end

   // magnitudes and result signs
   always_comb begin
      logic signed [m3inv_pkg::DET_W-1:0] det_abs;
      logic signed [m3inv_pkg::COF_W-1:0] c_abs;
      det_abs  = det_ff[m3inv_pkg::DET_W-1] ? -det_ff : det_ff;
      md5_in   = det_abs[m3inv_pkg::MAG_D_W-1:0];
      sing5_in = (det_ff == '0);
      for (int i = 0; i < NE; i++) begin
         c_abs      = cof4_ff[i][m3inv_pkg::COF_W-1] ? -cof4_ff[i] : cof4_ff[i];
         mc_in[i]   = c_abs[m3inv_pkg::MAG_C_W-1:0];
         neg5_in[i] = cof4_ff[i][m3inv_pkg::COF_W-1] ^ det_ff[m3inv_pkg::DET_W-1];
      end
   end

   // dividends with the half-divisor rounding term
   always_comb begin
      for (int i = 0; i < NE; i++) begin
         num_in[i] = (m3inv_pkg::NUM_W'(mc_ff[i]) << m3inv_pkg::Q_SHIFT)
                   + m3inv_pkg::NUM_W'(md5_ff >> 1);
      end
   end

   // divider entry: flag quotients that cannot fit the quotient width
   always_comb begin
      logic [m3inv_pkg::CMP_W-1:0] dmax;
      dmax          = {md6_ff, {m3inv_pkg::QUO_W{1'b0}}};
      dv_in[0].md   = md6_ff;
      dv_in[0].neg  = neg6_ff;
      dv_in[0].sing = sing6_ff;
      for (int i = 0; i < NE; i++) begin
         dv_in[0].rem[i] = num_ff[i];
         dv_in[0].quo[i] = '0;
         dv_in[0].big[i] = (m3inv_pkg::CMP_W'(num_ff[i]) >= dmax);
      end
   end

   // restoring divide, one quotient bit per stage
   for (genvar s = 0; s < DS; s++) begin : g_div
      localparam int unsigned K = DS - 1 - s;
      always_comb begin
         logic [m3inv_pkg::CMP_W-1:0] dsh;
         logic [m3inv_pkg::CMP_W-1:0] rext;
         logic [m3inv_pkg::CMP_W-1:0] diff;
         logic                        ge;
         dv_in[s+1] = dv_ff[s];
         dsh        = m3inv_pkg::CMP_W'(dv_ff[s].md) << K;
         for (int i = 0; i < NE; i++) begin
            rext = m3inv_pkg::CMP_W'(dv_ff[s].rem[i]);
            diff = rext - dsh;
            ge   = (rext >= dsh);
            if (ge) begin
               dv_in[s+1].rem[i] = diff[m3inv_pkg::NUM_W-1:0];
            end
            dv_in[s+1].quo[i] = {dv_ff[s].quo[i][m3inv_pkg::QUO_W-2:0], ge};
         end
      end
   end

   // sign, saturation and singular masking
   always_comb begin
      logic [m3inv_pkg::QUO_W-1:0] q;
      logic                        sat;
      ovf_in = 1'b0;
      for (int i = 0; i < NE; i++) begin
         q   = dv_ff[DS].quo[i];
         sat = dv_ff[DS].big[i]
            || (dv_ff[DS].neg[i] && (q > m3inv_pkg::NEG_LIMIT))
            || (!dv_ff[DS].neg[i] && (q > m3inv_pkg::POS_LIMIT));
         if (dv_ff[DS].sing) begin
            res_in[i] = '0;
         end else if (sat) begin
            res_in[i] = dv_ff[DS].neg[i] ? m3inv_pkg::NEG_SAT : m3inv_pkg::POS_SAT;
            ovf_in    = 1'b1;
         end else if (dv_ff[DS].neg[i]) begin
            res_in[i] = -q[m3inv_pkg::RES_W-1:0];
         end else begin
            res_in[i] = q[m3inv_pkg::RES_W-1:0];
         end
      end
   end

   // front pipeline payload
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         a_ff     <= a_in;
         pp_ff    <= pp_in;
         pm_ff    <= pm_in;
         r1a_ff   <= '{a_ff[0], a_ff[1], a_ff[2]};
         r2a_ff   <= r1a_ff;
         cof_ff   <= cof_in;
         cof3_ff  <= cof_ff;
         dp_ff    <= dp_in;
         cof4_ff  <= cof3_ff;
         det_ff   <= det_in;
         mc_ff    <= mc_in;
         md5_ff   <= md5_in;
         neg5_ff  <= neg5_in;
         sing5_ff <= sing5_in;
         num_ff   <= num_in;
         md6_ff   <= md5_ff;
         neg6_ff  <= neg5_ff;
         sing6_ff <= sing5_ff;
         dv_ff    <= dv_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (pipe_en && vld_ff[NST-1]) begin
         res_ff  <= res_in;
         sing_ff <= dv_ff[DS].sing;
         ovf_ff  <= ovf_in;
      end
   end

   assign rsp.valid    = out_vld_ff;
   assign rsp.r00      = res_ff[0];
   assign rsp.r01      = res_ff[1];
   assign rsp.r02      = res_ff[2];
   assign rsp.r10      = res_ff[3];
   assign rsp.r11      = res_ff[4];
   assign rsp.r12      = res_ff[5];
   assign rsp.r20      = res_ff[6];
   assign rsp.r21      = res_ff[7];
   assign rsp.r22      = res_ff[8];
   assign rsp.singular = sing_ff;
   assign rsp.overflow = ovf_ff;

   // checks
   `M3INV_ASSERT_NEXT(a_accept_enters, clock, reset, req.valid && req.ready, vld_ff[0],
      "accepted beat did not enter the first stage")
   `M3INV_ASSERT_IMPL(a_full_stall, clock, reset,
      vld_ff[NST-1] && out_vld_ff && !rsp.ready, !req.ready,
      "pipeline advanced over a waiting result")
   `M3INV_ASSERT_NEXT(a_last_to_out, clock, reset, vld_ff[NST-1] && pipe_en, rsp.valid,
      "last stage moved without filling the output register")
   `M3INV_ASSERT_IMPL(a_singular_clean, clock, reset, rsp.valid && rsp.singular,
      !rsp.overflow && (rsp.r00 == '0) && (rsp.r22 == '0),
      "singular result carries nonzero data or overflow")

endmodule
